// ===== rtl/b64d_pkg.sv =====
package b64d_pkg;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_CHAR   = 2'd1,
    STATUS_BAD_LENGTH = 2'd2
  } status_t;

  // results caused by one character: up to three bytes, then an optional status
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nbytes;
    logic            status;
    status_t         code;
  } bundle_t;

  localparam logic [7:0] CH_PAD   = 8'h3D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // {symbol ok, 6-bit value}
  function automatic logic [6:0] sym_lookup(input logic [7:0] ch);
    logic [7:0] t;
    t = 8'd0;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      t = ch - 8'h41;
      return {1'b1, t[5:0]};
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      t = ch - 8'd71;
      return {1'b1, t[5:0]};
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      t = ch + 8'd4;
      return {1'b1, t[5:0]};
    end else if (ch == 8'h2B) begin
      return {1'b1, 6'd62};
    end else if (ch == 8'h2F) begin
      return {1'b1, 6'd63};
    end
    return 7'd0;
  endfunction

endpackage

// ===== rtl/b64d_decode.sv =====
module b64d_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  logic [7:0]        char_in,
  input  logic              end_of_text,
  output b64d_pkg::bundle_t bundle,
  output logic              bundle_nz
);
  import b64d_pkg::*;

  logic [1:0]  pos_r, pos_nxt;
  logic [17:0] acc_r, acc_nxt;
  logic        tp_r, tp_nxt;
  logic        err_r, err_nxt;

  logic [6:0]  sym;
  logic        space, pad;
  logic [5:0]  val;
  logic        err_grp, tp_grp;
  logic [23:0] word;

  always_comb begin
    sym     = sym_lookup(char_in);
    space   = (char_in == CH_SPACE) || (char_in == CH_TAB) ||
              (char_in == CH_CR) || (char_in == CH_LF);
    pad     = (char_in == CH_PAD);
    val     = (pad || !sym[6]) ? 6'd0 : sym[5:0];
    err_grp = err_r || (pad && (pos_r < 2'd2)) || (!pad && !sym[6]) ||
              (!pad && sym[6] && (pos_r == 2'd3) && tp_r);
    tp_grp  = tp_r || (pad && (pos_r == 2'd2));
    word    = {acc_r, val};

    pos_nxt = pos_r;
    acc_nxt = acc_r;
    tp_nxt  = tp_r;
    err_nxt = err_r;

    bundle        = '0;
    bundle.code   = STATUS_OK;

    if (!space) begin
      err_nxt = err_grp;
      tp_nxt  = tp_grp;
      if (pos_r != 2'd3) begin
        acc_nxt = {acc_r[11:0], val};
        pos_nxt = pos_r + 2'd1;
      end else begin
        if (!err_grp) begin
          bundle.bytes  = {word[7:0], word[15:8], word[23:16]};
          bundle.nbytes = tp_grp ? 2'd1 : (pad ? 2'd2 : 2'd3);
        end
        pos_nxt = 2'd0;
        acc_nxt = 18'd0;
        tp_nxt  = 1'b0;
      end
    end

    if (end_of_text) begin
      bundle.status = 1'b1;
      if (err_nxt) begin
        bundle.code = STATUS_BAD_CHAR;
      end else if (pos_nxt != 2'd0) begin
        bundle.code = STATUS_BAD_LENGTH;
      end else begin
        bundle.code = STATUS_OK;
      end
      pos_nxt = 2'd0;
      acc_nxt = 18'd0;
      tp_nxt  = 1'b0;
      err_nxt = 1'b0;
    end

    bundle_nz = (bundle.nbytes != 2'd0) || bundle.status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 2'd0;
      acc_r <= 18'd0;
      tp_r  <= 1'b0;
      err_r <= 1'b0;
    end else if (item_valid) begin
      pos_r <= pos_nxt;
      acc_r <= acc_nxt;
      tp_r  <= tp_nxt;
      err_r <= err_nxt;
    end
  end

  // end of message always leaves a clean group
  a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid && end_of_text) |=> (pos_r == 2'd0 && !err_r && !tp_r))
    else $error("state not cleared after end of text");

endmodule

// ===== rtl/b64d_emit.sv =====
module b64d_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  b64d_pkg::bundle_t bundle_in,
  output logic              free,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,  // data_byte[7:0], status_code[9:8], zeros
  output logic [1:0]        out_tuser,  // has_byte[0], message_done[1]
  output logic              out_tlast
);
  import b64d_pkg::*;

  logic    bund_valid_r;
  bundle_t bund_r;
  logic [1:0] idx_r;

  logic [2:0] total;
  logic       last_entry, is_byte, fire;
  logic [7:0] byte_out;
  status_t    code_out;

  always_comb begin
    total      = {1'b0, bund_r.nbytes} + {2'b00, bund_r.status};
    last_entry = (({1'b0, idx_r} + 3'd1) == total);
    is_byte    = (idx_r < bund_r.nbytes);
    case (idx_r)
      2'd0:    byte_out = bund_r.bytes[0];
      2'd1:    byte_out = bund_r.bytes[1];
      2'd2:    byte_out = bund_r.bytes[2];
      default: byte_out = 8'd0;
    endcase
    if (!is_byte) begin
      byte_out = 8'd0;
    end
    code_out   = is_byte ? STATUS_OK : bund_r.code;
    fire       = out_tvalid && out_tready;
    free       = !bund_valid_r || (fire && last_entry);
  end

  assign out_tvalid = bund_valid_r;
  assign out_tdata  = {6'd0, code_out, byte_out};
  assign out_tuser  = {!is_byte, is_byte};
  assign out_tlast  = last_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bund_valid_r <= 1'b0;
      idx_r        <= 2'd0;
    end else if (load) begin
      bund_valid_r <= 1'b1;
      idx_r        <= 2'd0;
    end else if (fire) begin
      if (last_entry) begin
        bund_valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bund_r <= bundle_in;
    end
  end

  a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    bund_valid_r |-> (total != 3'd0 && {1'b0, idx_r} < total))
    else $error("result index outside bundle");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("bundle overwritten before drained");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && last_entry && !load) |=> !out_tvalid)
    else $error("output still valid after last result");

endmodule

// ===== rtl/base64_stream_decoder.sv =====
// Streaming Base64 (standard alphabet) decoder. One character is accepted per
// transaction on the in_ side, tlast marking the final character of a message;
// whitespace is skipped. Each completed group of four symbols yields one to
// three byte transactions, and the final character yields a closing status
// transaction (tuser[1] set, tdata[9:8] = 0 ok, 1 bad character, 2 bad length).
// tlast on the out_ side marks the last result caused by a given character.
// Bytes already sent are not withdrawn on error and none follow it, so the
// consumer discards the message when the status says so. A character is taken
// every cycle as long as each yields at most one result and out_tready is high;
// a character that closes a group or a message holds the single result port
// until all its results (up to four) are taken, and the input stalls only while
// a bundle drains.
module base64_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // char_in[7:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // data_byte[7:0], status_code[9:8], zeros
  output logic [1:0]  out_tuser,  // has_byte[0], message_done[1]
  output logic        out_tlast
);
  import b64d_pkg::*;

  logic       in_valid_r;
  logic [7:0] in_char_r;
  logic       in_eot_r;

  logic    adv, free, bundle_nz;
  bundle_t bundle;

  assign adv       = in_valid_r && free;
  assign in_tready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_char_r <= in_tdata;
      in_eot_r  <= in_tlast;
    end
  end

  b64d_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (adv),
    .char_in     (in_char_r),
    .end_of_text (in_eot_r),
    .bundle      (bundle),
    .bundle_nz   (bundle_nz)
  );

  b64d_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (adv && bundle_nz),
    .bundle_in  (bundle),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== test/tb.sv =====
module tb;
  import b64d_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       done;
    status_t    code;
    logic       tail;
  } result_t;

  class decode_tracker;
    logic [1:0]  grp_pos;
    logic [17:0] acc;
    logic        third_pad;
    logic        bad;
    result_t     due[$];
    int          errors;
    int          n_bytes;
    int          n_status[3];

    function new();
      errors = 0;
      n_bytes = 0;
      n_status = '{0, 0, 0};
      clear();
    endfunction

    function void clear();
      grp_pos = '0;
      acc = '0;
      third_pad = 1'b0;
      bad = 1'b0;
    endfunction

    function void push_result(logic [7:0] data, logic has, logic done, status_t code);
      result_t r;
      r.data = data;
      r.has = has;
      r.done = done;
      r.code = code;
      r.tail = 1'b0;
      due = {due, r};
    endfunction

    // six-bit symbol value, ok low outside the alphabet
    function void symbol_value(input logic [7:0] ch, output logic ok, output logic [5:0] v);
      logic [7:0] t;
      ok = 1'b1;
      t = 8'd0;
      if (ch >= "A" && ch <= "Z") t = ch - "A";
      else if (ch >= "a" && ch <= "z") t = ch - "a" + 8'd26;
      else if (ch >= "0" && ch <= "9") t = ch - "0" + 8'd52;
      else if (ch == "+") t = 8'd62;
      else if (ch == "/") t = 8'd63;
      else ok = 1'b0;
      v = t[5:0];
    endfunction

    function void take_char(logic [7:0] ch, logic eot);
      int         first;
      logic       is_pad;
      logic       ok;
      logic [5:0] v;
      logic [23:0] word;
      status_t    code;
      first = due.size();
      if (!(ch == CH_SPACE || ch == CH_TAB || ch == CH_CR || ch == CH_LF)) begin
        is_pad = (ch == CH_PAD);
        symbol_value(ch, ok, v);
        if (!ok) v = '0;
        if (is_pad) begin
          if (grp_pos < 2) bad = 1'b1;
          if (grp_pos == 2) third_pad = 1'b1;
        end else if (!ok) begin
          bad = 1'b1;
        end else if (grp_pos == 3 && third_pad) begin
          bad = 1'b1;
        end
        if (grp_pos != 2'd3) begin
          acc = {acc[11:0], v};
          grp_pos = grp_pos + 2'd1;
        end else begin
          word = {acc, v};
          if (!bad) begin
            push_result(word[23:16], 1'b1, 1'b0, STATUS_OK);
            if (!third_pad) push_result(word[15:8], 1'b1, 1'b0, STATUS_OK);
            if (!is_pad) push_result(word[7:0], 1'b1, 1'b0, STATUS_OK);
          end
          grp_pos = '0;
          acc = '0;
          third_pad = 1'b0;
        end
      end
      if (eot) begin
        code = bad ? STATUS_BAD_CHAR : (grp_pos != 0 ? STATUS_BAD_LENGTH : STATUS_OK);
        push_result(8'h00, 1'b0, 1'b1, code);
        clear();
      end
      if (due.size() > first) due[due.size()-1].tail = 1'b1;
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task check_output(logic [15:0] tdata, logic [1:0] tuser, logic tlast);
      result_t got;
      result_t exp;
      got.data = tdata[7:0];
      got.code = status_t'(tdata[9:8]);
      got.has = tuser[0];
      got.done = tuser[1];
      got.tail = tlast;
      if (tdata[15:10] !== 6'd0) report($sformatf("tdata padding bits %h", tdata[15:10]));
      if (due.size() == 0) begin
        report($sformatf("unexpected transaction data %h has %b done %b code %0d last %b",
                         got.data, got.has, got.done, got.code, got.tail));
      end else begin
        exp = due.pop_front();
        if (got !== exp)
          report($sformatf("got data %h has %b done %b code %0d last %b, exp %h %b %b %0d %b",
                           got.data, got.has, got.done, got.code, got.tail,
                           exp.data, exp.has, exp.done, exp.code, exp.tail));
        if (exp.done) n_status[exp.code]++;
        else n_bytes++;
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  decode_tracker tracker = new();

  int burst_left = 0;
  int sym_sent = 0;
  int chars_sent = 0;
  int msgs_sent = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int rcv_tick = 0;

  base64_stream_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  initial begin
    #3000000;
    $display("base64_stream_decoder test failed");
    $finish;
  end

  // receiver back-pressure, in one of four randomly chosen modes
  always @(negedge clk) begin
    rcv_tick <= rcv_tick + 1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= $urandom_range(0, 1);
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= (rcv_tick % 3 != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.check_output(out_tdata, out_tuser, out_tlast);
  end

  function automatic logic is_ws(logic [7:0] ch);
    return ch == CH_SPACE || ch == CH_TAB || ch == CH_CR || ch == CH_LF;
  endfunction

  function automatic logic [7:0] ws_char();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] b64_char(logic [5:0] v);
    if (v < 26) return "A" + v;
    if (v < 52) return "a" + v - 8'd26;
    if (v < 62) return "0" + v - 8'd52;
    return (v == 62) ? "+" : "/";
  endfunction

  task automatic send_char(logic [7:0] ch, logic eot);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= ch;
    in_tlast <= eot;
    do @(posedge clk); while (!in_tready);
    tracker.take_char(ch, eot);
    burst_left--;
    chars_sent++;
    if (!is_ws(ch)) sym_sent++;
  endtask

  task automatic send_msg(ref logic [7:0] m[$]);
    foreach (m[i]) send_char(m[i], i == m.size() - 1);
    msgs_sent++;
  endtask

  task automatic send_text(string s);
    logic [7:0] m[$];
    for (int i = 0; i < s.len(); i++) m = {m, s[i]};
    send_msg(m);
  endtask

  // random payload, encoded with padding and sprinkled whitespace
  task automatic make_clean(ref logic [7:0] m[$]);
    int          n;
    logic [7:0]  raw[$];
    logic [7:0]  enc[$];
    logic [23:0] w;
    n = $urandom_range(0, 9);
    repeat (n) raw = {raw, 8'($urandom_range(0, 255))};
    for (int i = 0; i < n; i += 3) begin
      w = {raw[i], (i + 1 < n) ? raw[i+1] : 8'h00, (i + 2 < n) ? raw[i+2] : 8'h00};
      enc = {enc, b64_char(w[23:18])};
      enc = {enc, b64_char(w[17:12])};
      enc = {enc, (i + 1 < n) ? b64_char(w[11:6]) : CH_PAD};
      enc = {enc, (i + 2 < n) ? b64_char(w[5:0]) : CH_PAD};
    end
    m.delete();
    foreach (enc[i]) begin
      if ($urandom_range(0, 7) == 0) m = {m, ws_char()};
      m = {m, enc[i]};
    end
    if (m.size() == 0 || $urandom_range(0, 5) == 0) m = {m, ws_char()};
  endtask

  initial begin
    logic [7:0] m[$];
    int         waited;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_text("\t/+9z");
    send_text("QUI=\r");
    send_text("QQ==");
    send_text("=AB");
    send_text("AB=C");
    send_text("\nQU");
    send_text(" ");
    m = '{8'h00, 8'hFF};
    send_msg(m);

    while (chars_sent < 300) begin
      make_clean(m);
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: begin
            m.delete();
            repeat ($urandom_range(1, 8)) m = {m, 8'($urandom_range(0, 255))};
          end
          1: m[$urandom_range(0, m.size() - 1)] = $urandom_range(0, 255);
          2: m[$urandom_range(0, m.size() - 1)] = CH_PAD;
          default: m.delete($urandom_range(0, m.size() - 1));
        endcase
        if (m.size() == 0) m = {m, ws_char()};
      end
      send_msg(m);
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    waited = 0;
    while (tracker.due.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (tracker.due.size() != 0)
      tracker.report($sformatf("%0d results never arrived", tracker.due.size()));

    $display("%0d characters (%0d symbols) in %0d messages sent, %0d decoded bytes checked",
             chars_sent, sym_sent, msgs_sent, tracker.n_bytes);
    $display("closing statuses: %0d ok, %0d bad character, %0d bad length",
             tracker.n_status[STATUS_OK], tracker.n_status[STATUS_BAD_CHAR],
             tracker.n_status[STATUS_BAD_LENGTH]);
    if (tracker.errors == 0) begin
      $display("base64_stream_decoder test passed");
    end else begin
      $display("base64_stream_decoder test failed");
    end
    $finish;
  end

endmodule
